// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/fcle_pkg.sv =====
`default_nettype none
package fcle_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 7;
  localparam int IDX_W        = 6;
  localparam int CAPACITY_DEF = 64;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_SEARCH  = 3'd3;
  localparam logic [2:0] OP_EXTREME = 3'd4;
  localparam logic [2:0] OP_SORT    = 3'd5;
  localparam logic [2:0] OP_DUMP    = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADIDX   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] operand_value;
    logic                     ascending;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] data_value;
    logic signed [DATA_W-1:0] min_value;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         length;
    logic                     is_empty;
    logic                     is_full;
    logic                     last;
  } rsp_t;

  // Micro-operations issued by the controller to the datapath.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_RES_OK,
    CMD_RES_FULL,
    CMD_RES_EMPTY,
    CMD_RES_BAD,
    CMD_RES_NF,
    CMD_RES_FOUND,
    CMD_RES_EXT,
    CMD_INS_INIT,
    CMD_RD_IDXM1,
    CMD_WR_IDX,
    CMD_INS_PUT,
    CMD_DEL_INIT,
    CMD_DEL_CAP,
    CMD_RD_IDX,
    CMD_WR_IDXM1,
    CMD_DEL_DONE,
    CMD_IDX0,
    CMD_IDX_INC,
    CMD_EXT_INIT,
    CMD_EXT_CAP,
    CMD_EXT_UPD,
    CMD_SRT_INIT,
    CMD_SRT_PASS,
    CMD_SRT_CAP,
    CMD_RD_IDXP1,
    CMD_SRT_STEP,
    CMD_SRT_END,
    CMD_DMP_PUSH,
    CMD_PUSH
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       pos_gt_n;
    logic       pos_ge_n;
    logic       idx_gt_pos;
    logic       idx_lt_n;
    logic       idx1_lt_lim;
    logic       lim_gt_1;
    logic       rd_eq_val;
    logic       slot_free;
    logic       dmp_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcle_ram.sv =====
`default_nettype none
module fcle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fcle_dp.sv =====
`default_nettype none
module fcle_dp import fcle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     cmd,
  input  wire req_t     req,
  input  wire logic     rsp_stall,
  output dp_stat_t      stat,
  output logic          rsp_valid,
  output rsp_t          rsp
);

  logic [2:0]        op;
  logic [CNT_W-1:0]  pos;
  logic [DATA_W-1:0] val;
  logic              asc;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  lim;
  logic [DATA_W-1:0] hold;
  logic [DATA_W-1:0] mx;
  logic [DATA_W-1:0] mn;
  logic [2:0]        res_status;
  logic [DATA_W-1:0] res_data;
  logic [DATA_W-1:0] res_min;
  logic [IDX_W-1:0]  res_idx;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  idx_p1;
  logic              swap;
  logic              slot_free;
  logic              full;

  fcle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_m1    = idx - CNT_W'(1);
  assign idx_p1    = idx + CNT_W'(1);
  assign full      = (count == CNT_W'(CAPACITY));
  assign slot_free = !rsp_valid || !rsp_stall;
  assign swap      = asc ? ($signed(hold) > $signed(rdata))
                         : ($signed(hold) < $signed(rdata));

  always_comb begin
    stat.op          = op;
    stat.full        = full;
    stat.empty       = (count == '0);
    stat.pos_gt_n    = (pos > count);
    stat.pos_ge_n    = (pos >= count);
    stat.idx_gt_pos  = (idx > pos);
    stat.idx_lt_n    = (idx < count);
    stat.idx1_lt_lim = (idx_p1 < lim);
    stat.lim_gt_1    = (lim > CNT_W'(1));
    stat.rd_eq_val   = (rdata == val);
    stat.slot_free   = slot_free;
    stat.dmp_last    = (idx_p1 == count);
  end

  // Memory port steering.
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    re    = 1'b0;
    raddr = idx[AW-1:0];
    case (cmd)
      CMD_RD_IDXM1: begin
        re    = 1'b1;
        raddr = idx_m1[AW-1:0];
      end
      CMD_WR_IDX: begin
        we = 1'b1;
      end
      CMD_INS_PUT: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = val;
      end
      CMD_DEL_INIT: begin
        re    = 1'b1;
        raddr = pos[AW-1:0];
      end
      CMD_RD_IDX: begin
        re = 1'b1;
      end
      CMD_WR_IDXM1: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
      end
      CMD_EXT_INIT, CMD_SRT_PASS: begin
        re    = 1'b1;
        raddr = '0;
      end
      CMD_RD_IDXP1: begin
        re    = 1'b1;
        raddr = idx_p1[AW-1:0];
      end
      CMD_SRT_STEP: begin
        we    = 1'b1;
        wdata = swap ? rdata : hold;
      end
      CMD_SRT_END: begin
        we    = 1'b1;
        wdata = hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op  <= req.opcode;
        pos <= req.position;
        val <= req.operand_value;
        asc <= req.ascending;
      end
      CMD_CLEAR, CMD_RES_OK, CMD_INS_PUT: begin
        res_status <= ST_OK;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_RES_FULL: begin
        res_status <= ST_FULL;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_RES_EMPTY: begin
        res_status <= ST_EMPTY;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_RES_BAD: begin
        res_status <= ST_BADIDX;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_RES_NF: begin
        res_status <= ST_NOTFOUND;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_RES_FOUND: begin
        res_status <= ST_OK;
        res_data   <= '0;
        res_min    <= '0;
        res_idx    <= idx[IDX_W-1:0];
      end
      CMD_RES_EXT: begin
        res_status <= ST_OK;
        res_data   <= mx;
        res_min    <= mn;
        res_idx    <= '0;
      end
      CMD_DEL_DONE: begin
        res_status <= ST_OK;
        res_min    <= '0;
        res_idx    <= '0;
      end
      CMD_INS_INIT: begin
        idx <= count;
      end
      CMD_WR_IDX: begin
        idx <= idx_m1;
      end
      CMD_DEL_INIT: begin
        idx <= pos + CNT_W'(1);
      end
      CMD_DEL_CAP: begin
        res_data <= rdata;
      end
      CMD_WR_IDXM1, CMD_IDX_INC: begin
        idx <= idx_p1;
      end
      CMD_IDX0, CMD_SRT_PASS: begin
        idx <= '0;
      end
      CMD_EXT_INIT: begin
        idx <= CNT_W'(1);
      end
      CMD_EXT_CAP: begin
        mx <= rdata;
        mn <= rdata;
      end
      CMD_EXT_UPD: begin
        if ($signed(rdata) > $signed(mx)) begin
          mx <= rdata;
        end
        if ($signed(rdata) < $signed(mn)) begin
          mn <= rdata;
        end
        idx <= idx_p1;
      end
      CMD_SRT_INIT: begin
        lim <= count;
      end
      CMD_SRT_CAP: begin
        hold <= rdata;
      end
      CMD_SRT_STEP: begin
        if (!swap) begin
          hold <= rdata;
        end
        idx <= idx_p1;
      end
      CMD_SRT_END: begin
        lim <= lim - CNT_W'(1);
      end
      CMD_DMP_PUSH: begin
        idx <= idx_p1;
      end
      default: begin
      end
    endcase
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd)
        CMD_CLEAR:    count <= '0;
        CMD_INS_PUT:  count <= count + CNT_W'(1);
        CMD_DEL_DONE: count <= count - CNT_W'(1);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd == CMD_PUSH || cmd == CMD_DMP_PUSH) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_PUSH) begin
      rsp.status      <= res_status;
      rsp.data_value  <= res_data;
      rsp.min_value   <= res_min;
      rsp.found_index <= res_idx;
      rsp.length      <= count;
      rsp.is_empty    <= (count == '0);
      rsp.is_full     <= full;
      rsp.last        <= 1'b1;
    end else if (cmd == CMD_DMP_PUSH) begin
      rsp.status      <= ST_OK;
      rsp.data_value  <= rdata;
      rsp.min_value   <= '0;
      rsp.found_index <= '0;
      rsp.length      <= count;
      rsp.is_empty    <= (count == '0);
      rsp.is_full     <= full;
      rsp.last        <= (idx_p1 == count);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fcle_ctrl.sv =====
`default_nettype none
module fcle_ctrl import fcle_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire dp_stat_t stat,
  output cmd_t          cmd,
  output logic          idle
);

  typedef enum logic [18:0] {
    S_IDLE     = 19'b0000000000000000001,
    S_DISP     = 19'b0000000000000000010,
    S_INS_RD   = 19'b0000000000000000100,
    S_INS_WR   = 19'b0000000000000001000,
    S_DEL_CAP  = 19'b0000000000000010000,
    S_DEL_RD   = 19'b0000000000000100000,
    S_DEL_WR   = 19'b0000000000001000000,
    S_SRC_RD   = 19'b0000000000010000000,
    S_SRC_CMP  = 19'b0000000000100000000,
    S_EXT_CAP  = 19'b0000000001000000000,
    S_EXT_RD   = 19'b0000000010000000000,
    S_EXT_CMP  = 19'b0000000100000000000,
    S_SRT_PASS = 19'b0000001000000000000,
    S_SRT_CAP  = 19'b0000010000000000000,
    S_SRT_RD   = 19'b0000100000000000000,
    S_SRT_CMP  = 19'b0001000000000000000,
    S_DMP_RD   = 19'b0010000000000000000,
    S_DMP_PUT  = 19'b0100000000000000000,
    S_EMIT     = 19'b1000000000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_EMIT;
        case (stat.op)
          OP_CLEAR: cmd = CMD_CLEAR;
          OP_INSERT: begin
            if (stat.full) begin
              cmd = CMD_RES_FULL;
            end else if (stat.pos_gt_n) begin
              cmd = CMD_RES_BAD;
            end else begin
              cmd        = CMD_INS_INIT;
              state_next = S_INS_RD;
            end
          end
          OP_DELETE: begin
            if (stat.empty) begin
              cmd = CMD_RES_EMPTY;
            end else if (stat.pos_ge_n) begin
              cmd = CMD_RES_BAD;
            end else begin
              cmd        = CMD_DEL_INIT;
              state_next = S_DEL_CAP;
            end
          end
          OP_SEARCH: begin
            cmd        = CMD_IDX0;
            state_next = S_SRC_RD;
          end
          OP_EXTREME: begin
            if (stat.empty) begin
              cmd = CMD_RES_EMPTY;
            end else begin
              cmd        = CMD_EXT_INIT;
              state_next = S_EXT_CAP;
            end
          end
          OP_SORT: begin
            cmd        = CMD_SRT_INIT;
            state_next = S_SRT_PASS;
          end
          OP_DUMP: begin
            if (stat.empty) begin
              cmd = CMD_RES_EMPTY;
            end else begin
              cmd        = CMD_IDX0;
              state_next = S_DMP_RD;
            end
          end
          default: cmd = CMD_RES_OK;
        endcase
      end
      S_INS_RD: begin
        if (stat.idx_gt_pos) begin
          cmd        = CMD_RD_IDXM1;
          state_next = S_INS_WR;
        end else begin
          cmd        = CMD_INS_PUT;
          state_next = S_EMIT;
        end
      end
      S_INS_WR: begin
        cmd        = CMD_WR_IDX;
        state_next = S_INS_RD;
      end
      S_DEL_CAP: begin
        cmd        = CMD_DEL_CAP;
        state_next = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (stat.idx_lt_n) begin
          cmd        = CMD_RD_IDX;
          state_next = S_DEL_WR;
        end else begin
          cmd        = CMD_DEL_DONE;
          state_next = S_EMIT;
        end
      end
      S_DEL_WR: begin
        cmd        = CMD_WR_IDXM1;
        state_next = S_DEL_RD;
      end
      S_SRC_RD: begin
        if (stat.idx_lt_n) begin
          cmd        = CMD_RD_IDX;
          state_next = S_SRC_CMP;
        end else begin
          cmd        = CMD_RES_NF;
          state_next = S_EMIT;
        end
      end
      S_SRC_CMP: begin
        if (stat.rd_eq_val) begin
          cmd        = CMD_RES_FOUND;
          state_next = S_EMIT;
        end else begin
          cmd        = CMD_IDX_INC;
          state_next = S_SRC_RD;
        end
      end
      S_EXT_CAP: begin
        cmd        = CMD_EXT_CAP;
        state_next = S_EXT_RD;
      end
      S_EXT_RD: begin
        if (stat.idx_lt_n) begin
          cmd        = CMD_RD_IDX;
          state_next = S_EXT_CMP;
        end else begin
          cmd        = CMD_RES_EXT;
          state_next = S_EMIT;
        end
      end
      S_EXT_CMP: begin
        cmd        = CMD_EXT_UPD;
        state_next = S_EXT_RD;
      end
      S_SRT_PASS: begin
        if (stat.lim_gt_1) begin
          cmd        = CMD_SRT_PASS;
          state_next = S_SRT_CAP;
        end else begin
          cmd        = CMD_RES_OK;
          state_next = S_EMIT;
        end
      end
      S_SRT_CAP: begin
        cmd        = CMD_SRT_CAP;
        state_next = S_SRT_RD;
      end
      S_SRT_RD: begin
        if (stat.idx1_lt_lim) begin
          cmd        = CMD_RD_IDXP1;
          state_next = S_SRT_CMP;
        end else begin
          cmd        = CMD_SRT_END;
          state_next = S_SRT_PASS;
        end
      end
      S_SRT_CMP: begin
        cmd        = CMD_SRT_STEP;
        state_next = S_SRT_RD;
      end
      S_DMP_RD: begin
        cmd        = CMD_RD_IDX;
        state_next = S_DMP_PUT;
      end
      S_DMP_PUT: begin
        if (stat.slot_free) begin
          cmd        = CMD_DMP_PUSH;
          state_next = stat.dmp_last ? S_IDLE : S_DMP_RD;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd        = CMD_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_capacity_list_engine_unit.sv =====
// Channel | Direction | Payload | Handshake
// req     | in        | req_t   | req_valid / req_stall
// rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// One item is worked at a time; the list lives in a single-port-read RAM whose
// read data is registered, so each element visited takes a read state followed
// by a write, compare or push state. Sort works by bubble passes over the RAM.
// Reset clears the element count and the control state; the RAM is not
// cleared. A stalled result register holds the machine before it pushes.
`default_nettype none
`include "assert_macros.svh"
module fixed_capacity_list_engine_unit import fcle_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // Controller and datapath exchange only a command code and a status bundle.
  cmd_t     cmd;
  dp_stat_t stat;
  logic     idle;

  // Items are taken only while the controller sits idle.
  assign req_stall = !idle;

  fcle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd),
    .idle      (idle)
  );

  fcle_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // An accepted item keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  // A reported length never exceeds the capacity.
  `ASSERT_IMPL(a_len_bound, clk, rst, rsp_valid, rsp.length <= CNT_W'(CAPACITY))
  // The empty flag agrees with the reported length.
  `ASSERT_IMPL(a_empty_flag, clk, rst, rsp_valid, rsp.is_empty == (rsp.length == '0))

endmodule
`default_nettype wire
